// ----- design/spgr_pkg.sv -----
// Package for the ramped step/direction pulse generator.
// Shared widths, codes and structs. No dependencies.
package spgr_pkg;

    localparam int TIME_W      = 32;  // elapsed-time counter width
    localparam int CNT_W       = 16;
    localparam int TICK_W      = 24;
    localparam int DELTA_W     = 16;
    localparam int LEN_W       = 10;
    localparam int OFFSET_W    = 26;  // ramp_length * ramp_delta
    localparam int BASE_W      = 26;  // high + low + extra
    localparam int LIMIT_W     = 27;  // base + offset
    localparam int CMP_W       = (TIME_W > LIMIT_W) ? TIME_W : LIMIT_W;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_TDATA_W = 8;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_TIME   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_TIME    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_EXTRA  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_ENABLE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_DELTA  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_LENGTH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DIR_FLIP    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION   = 3'd7;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Start status codes
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_ACCEPTED  = 2'd1;
    localparam logic [1:0] ST_REJ_BUSY  = 2'd2;
    localparam logic [1:0] ST_REJ_ZERO  = 2'd3;

    // Phase codes
    localparam logic [1:0] PH_INACTIVE = 2'd0;
    localparam logic [1:0] PH_ON       = 2'd1;
    localparam logic [1:0] PH_OFF      = 2'd2;

    typedef struct packed {
        logic [TICK_W-1:0]   high_time;
        logic [BASE_W-1:0]   base_time;   // high + low + rate extra
        logic [OFFSET_W-1:0] max_offset;  // ramp_length * ramp_delta
        logic                ramp_enable;
        logic [DELTA_W-1:0]  ramp_delta;
        logic [LEN_W-1:0]    ramp_length;
        logic                dir_level;
    } cfg_t;

    typedef struct packed {
        logic             command;
        logic [CNT_W-1:0] step_count;
    } item_t;

    typedef struct packed {
        logic       busy_res;
        logic       all_done;
        logic       step_done;
        logic [1:0] start_status;
        logic       dir_level;
        logic       step_level;
    } result_t;

endpackage

// ----- design/stepper_pulse_generator_ramped.sv -----
// Ramped step/direction pulse generator, top level.
// Each item passes the input register and then the result register on its way to the result.
// One item per cycle while m_tready does not stall the result; a tick or start may follow every cycle.
// The state update in spgr_step_engine lies between the two registers.
// Reset: synchronous active-low aresetn; registers to defaults, sequencer idle, no results.
// Depends on spgr_pkg, spgr_cfg_regs and spgr_step_engine.
module stepper_pulse_generator_ramped (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Item input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [spgr_pkg::CNT_W-1:0]         s_tdata,  // [15:0] step_count
    input  logic                               s_tuser,  // [0] command (0 tick, 1 start)
    // Result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] step_level, [1] dir_level, [3:2] start_status, [4] step_done,
    // [5] all_done, [6] busy_res, [7] zero
    output logic [spgr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // Register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spgr_pkg::TICK_W-1:0]        cfg_data
);
    import spgr_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    fire;

    // Register file always takes writes.
    assign cfg_ready = 1'b1;

    spgr_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Item is processed when the result register is free or draining this cycle.
    assign fire     = item_valid_reg && (!out_valid_reg || m_tready);
    // Input register takes a new item whenever its current one moves on.
    assign s_tready = !item_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.command    <= s_tuser;
            item_reg.step_count <= s_tdata;
        end
    end

    spgr_step_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result_reg.busy_res, result_reg.all_done, result_reg.step_done,
                       result_reg.start_status, result_reg.dir_level, result_reg.step_level};

endmodule

// ----- design/spgr_cfg_regs.sv -----
// Configuration register file for the pulse generator.
// Holds the eight registers and the precomputed base time and ramp ceiling. Uses spgr_pkg.
module spgr_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [spgr_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [spgr_pkg::TICK_W-1:0]      wr_data,
    output spgr_pkg::cfg_t                  cfg
);
    import spgr_pkg::*;

    logic [TICK_W-1:0]   high_time_reg, low_time_reg, rate_extra_reg;
    logic                ramp_enable_reg, dir_flip_reg, direction_reg;
    logic [DELTA_W-1:0]  ramp_delta_reg;
    logic [LEN_W-1:0]    ramp_length_reg;
    logic [BASE_W-1:0]   base_time_reg;
    logic [OFFSET_W-1:0] max_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_time_reg   <= TICK_W'(10);
            low_time_reg    <= TICK_W'(10);
            rate_extra_reg  <= '0;
            ramp_enable_reg <= 1'b0;
            ramp_delta_reg  <= '0;
            ramp_length_reg <= '0;
            dir_flip_reg    <= 1'b0;
            direction_reg   <= 1'b0;
        end else if (wr_en) begin
            case (wr_index)
                REG_HIGH_TIME:   high_time_reg   <= wr_data;
                REG_LOW_TIME:    low_time_reg    <= wr_data;
                REG_RATE_EXTRA:  rate_extra_reg  <= wr_data;
                REG_RAMP_ENABLE: ramp_enable_reg <= wr_data[0];
                REG_RAMP_DELTA:  ramp_delta_reg  <= wr_data[DELTA_W-1:0];
                REG_RAMP_LENGTH: ramp_length_reg <= wr_data[LEN_W-1:0];
                REG_DIR_FLIP:    dir_flip_reg    <= wr_data[0];
                REG_DIRECTION:   direction_reg   <= wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // Derived values, registered from the registers. Writes must come only while idle; nothing here enforces it.
    always_ff @(posedge aclk) begin
        base_time_reg  <= BASE_W'(high_time_reg) + BASE_W'(low_time_reg)
                        + BASE_W'(rate_extra_reg);
        max_offset_reg <= OFFSET_W'(ramp_length_reg) * OFFSET_W'(ramp_delta_reg);
    end

    always_comb begin
        cfg.high_time   = high_time_reg;
        cfg.base_time   = base_time_reg;
        cfg.max_offset  = max_offset_reg;
        cfg.ramp_enable = ramp_enable_reg;
        cfg.ramp_delta  = ramp_delta_reg;
        cfg.ramp_length = ramp_length_reg;
        cfg.dir_level   = direction_reg ^ dir_flip_reg;
    end

endmodule

// ----- design/spgr_step_engine.sv -----
// Step sequencer state and per-item next-state logic.
// Updates phase, elapsed time, step count, ramp offset and ramp point on each transfer. Uses spgr_pkg.
module spgr_step_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  spgr_pkg::item_t   item,
    input  spgr_pkg::cfg_t    cfg,
    output spgr_pkg::result_t result
);
    import spgr_pkg::*;

    logic [1:0]          phase_reg, phase_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]    steps_left_reg, steps_left_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0]    point_reg, point_next;

    logic                busy;
    logic [TIME_W-1:0]   elapsed_inc;
    logic [LIMIT_W-1:0]  limit;
    logic [LIMIT_W-1:0]  off_up;
    logic [OFFSET_W-1:0] off_up_capped, off_down, off_stepped;
    logic [CNT_W-1:0]    steps_dec;
    logic [1:0]          status;
    logic                sdone, adone;

    assign busy        = (phase_reg == PH_ON) || (phase_reg == PH_OFF);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign limit       = LIMIT_W'(cfg.base_time) + LIMIT_W'(offset_reg);

    // Ramp offset after a completed step: rise (capped) in the final ramp, else fall by ramp_delta toward 0.
    // The window test uses the count left once this step is taken off.
    assign steps_dec     = steps_left_reg - 1'b1;
    assign off_up        = LIMIT_W'(offset_reg) + LIMIT_W'(cfg.ramp_delta);
    assign off_up_capped = (off_up > LIMIT_W'(cfg.max_offset)) ? cfg.max_offset
                                                               : off_up[OFFSET_W-1:0];
    assign off_down      = (offset_reg > OFFSET_W'(cfg.ramp_delta))
                         ? offset_reg - OFFSET_W'(cfg.ramp_delta) : '0;
    assign off_stepped   = (steps_dec < point_reg) ? off_up_capped : off_down;

    always_comb begin
        phase_next      = phase_reg;
        elapsed_next    = elapsed_reg;
        steps_left_next = steps_left_reg;
        offset_next     = offset_reg;
        point_next      = point_reg;
        status          = ST_NONE;
        sdone           = 1'b0;
        adone           = 1'b0;

        if (item.command == CMD_START) begin
            if (busy) begin
                status = ST_REJ_BUSY;
            end else if (item.step_count == '0) begin
                status = ST_REJ_ZERO;
            end else begin
                status          = ST_ACCEPTED;
                steps_left_next = item.step_count - 1'b1;
                if (cfg.ramp_enable) begin
                    offset_next = cfg.max_offset;
                    point_next  = ((CNT_W+1)'(item.step_count) < {cfg.ramp_length, 1'b0})
                                ? (item.step_count >> 1) : CNT_W'(cfg.ramp_length);
                end else begin
                    offset_next = '0;
                end
                elapsed_next = '0;
                phase_next   = PH_ON;
            end
        end else if (busy) begin
            elapsed_next = elapsed_inc;
            if (phase_reg == PH_ON) begin
                if (CMP_W'(elapsed_inc) >= CMP_W'(cfg.high_time)) begin
                    phase_next = PH_OFF;
                end
            end else if (CMP_W'(elapsed_inc) >= CMP_W'(limit)) begin
                sdone = 1'b1;
                if (steps_left_reg != '0) begin
                    elapsed_next    = '0;
                    steps_left_next = steps_left_reg - 1'b1;
                    if (cfg.ramp_enable) begin
                        offset_next = off_stepped;
                    end
                    phase_next = PH_ON;
                end else begin
                    phase_next = PH_INACTIVE;
                    adone      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_INACTIVE;
            elapsed_reg    <= '0;
            steps_left_reg <= '0;
            offset_reg     <= '0;
            point_reg      <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            steps_left_reg <= steps_left_next;
            offset_reg     <= offset_next;
            point_reg      <= point_next;
        end
    end

    always_comb begin
        result.step_level   = (phase_next == PH_ON);
        result.dir_level    = cfg.dir_level;
        result.start_status = status;
        result.step_done    = sdone;
        result.all_done     = adone;
        result.busy_res     = (phase_next == PH_ON) || (phase_next == PH_OFF);
    end

endmodule

// ----- design/spgr_checker.sv -----
// Port-level checker for the pulse generator, bound to the top level.
// Watches only the top-level ports. Uses spgr_pkg.
module spgr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [spgr_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import spgr_pkg::*;

    // No result survives reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Last step ends a step and leaves the sequencer idle.
    a_all_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[4] && !m_tdata[6])
        else $error("all_done without step_done or while busy");

    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[6])
        else $error("step line high while idle");

    // Start items pass no time.
    a_start_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:2] != ST_NONE) |-> !m_tdata[4] && !m_tdata[5])
        else $error("done pulse on a start result");

endmodule

bind stepper_pulse_generator_ramped spgr_checker u_spgr_checker (.*);
